// ===== design/rhr_pkg.sv =====
package rhr_pkg;

    typedef struct packed {
        logic               op;
        logic signed [31:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               ready_res;
    } out_word_t;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes
    localparam logic [1:0] REG_SEED        = 2'd0;
    localparam logic [1:0] REG_ROUNDS      = 2'd1;
    localparam logic [1:0] REG_LOG2_SIZE   = 2'd2;
    localparam logic [1:0] REG_USED_LENGTH = 2'd3;

    localparam int LC_W = 11;

    // stage multiplier and splitmix64 constants
    localparam logic [63:0] K_STAGE = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] K_GOLD  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] K_MIX1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] K_MIX2  = 64'h94D0_49BB_1331_11EB;

    // scale factors for even and odd total exponent
    localparam logic [31:0] C_EVEN = 32'h8000_0000;
    localparam logic [31:0] C_ODD  = 32'd1518500250;

endpackage

// ===== design/randomized_hadamard_rotation_core.sv =====
// Randomized Walsh-Hadamard rotation of one Q16.16 vector. Words with op load
// fill the buffer in order; the load that reaches used_length (clamped to
// 1..n, n = 2^log2_size) starts the transform, during which s_ready is low.
// The transform zero-pads entries used..n-1, then for every round runs a sign
// pass, paced by the splitmix64 hash pipeline, and log2(n) butterfly levels
// (n/2 butterflies per level, paced by the single write port of the buffer
// memory), and ends with a scale pass through the 32x32 multiplier pipeline.
// After a read word s_ready stays low until its buffer data has been read out.
// A read before the transform has finished returns value 0 with ready_res 0.
// The buffer holds 64-bit entries and has no reset; its contents are defined
// once written.
module randomized_hadamard_rotation_core
    import rhr_pkg::*;
#(
    parameter int MAX_LENGTH = 1024,
    parameter int MAX_ROUNDS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CW   = $clog2(MAX_LENGTH + 1);
    localparam int LMAX = $clog2(MAX_LENGTH + 1) - 1;
    localparam logic [3:0] LCLAMP = (LMAX > 15) ? 4'd15 : 4'(LMAX);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_BFLY  = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;

    // configuration registers
    logic [63:0]       seed_reg;
    logic [2:0]        rounds_reg;
    logic [3:0]        log2_reg;
    logic [10:0]       used_reg;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [2:0]        s_reg, s_next;
    logic [63:0]       sk_reg, sk_next;
    logic [63:0]       ik_reg, ik_next;
    logic [3:0]        l_reg, l_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [2:0]        r_reg, r_next;
    logic [6:0]        e_reg, e_next;

    // item bookkeeping
    logic [LC_W-1:0]   lc_reg, lc_next;
    logic [CW-1:0]     rc_reg, rc_next;
    logic              done_reg, done_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    // buffer memory
    logic [63:0]       mem [MAX_LENGTH];
    logic [AW-1:0]     addr_a, addr_b, waddr;
    logic              we;
    logic [63:0]       wdata;
    logic [63:0]       rd_a_reg, rd_b_reg;

    // hash pipeline
    logic [63:0]       x_reg, hx;
    logic [63:0]       p0_reg;
    logic [31:0]       p1_reg, p2_reg;
    logic [63:0]       y_reg, hy;
    logic [31:0]       z_reg;
    logic              keep;

    // scale pipeline
    logic              neg_reg;
    logic [63:0]       m_reg;
    logic [63:0]       pq_reg, pp_reg;
    logic [95:0]       prod_reg;
    logic [31:0]       cmul;
    logic [6:0]        sh;
    logic [95:0]       rnd, shifted;
    logic [31:0]       lim, rmag;
    logic [63:0]       scaled;

    // butterfly
    logic [63:0]       diff_reg;
    logic [CW-1:0]     bf_mask, bf_j, bf_jb;

    // current-register views
    logic [3:0]        l_cur;
    logic [CW-1:0]     n_cur;
    logic [10:0]       used_raw;
    logic [CW-1:0]     used_eff;
    logic [2:0]        r_cur;
    logic [LC_W-1:0]   lc_eff, lc_inc;
    logic [CW-1:0]     rc_eff;
    logic              in_acc, out_acc, cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == ST_IDLE) && !pend_reg && (!m_valid_reg || m_ready);
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid_reg && m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= '0;
            rounds_reg <= 3'd3;
            log2_reg   <= 4'd10;
            used_reg   <= 11'd1024;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_SEED:        seed_reg   <= pwdata;
                REG_ROUNDS:      rounds_reg <= pwdata[2:0];
                REG_LOG2_SIZE:   log2_reg   <= pwdata[3:0];
                REG_USED_LENGTH: used_reg   <= pwdata[10:0];
                default:         seed_reg   <= seed_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_SEED:        prdata = seed_reg;
            REG_ROUNDS:      prdata = {61'd0, rounds_reg};
            REG_LOG2_SIZE:   prdata = {60'd0, log2_reg};
            REG_USED_LENGTH: prdata = {53'd0, used_reg};
            default:         prdata = '0;
        endcase
    end

    // effective size, rounds and used length as the registers stand now
    always_comb begin
        l_cur    = (log2_reg > LCLAMP) ? LCLAMP : log2_reg;
        n_cur    = CW'(1) << l_cur;
        used_raw = (used_reg == 11'd0) ? 11'd1 : used_reg;
        used_eff = (32'(used_raw) > 32'(n_cur)) ? n_cur : CW'(used_raw);
        r_cur    = ({1'b0, rounds_reg} > 4'(MAX_ROUNDS)) ? 3'(MAX_ROUNDS) : rounds_reg;
        lc_eff   = done_reg ? '0 : lc_reg;
        lc_inc   = lc_eff + 1'b1;
        rc_eff   = (rc_reg >= n_cur) ? '0 : rc_reg;
    end

    // hash: keep bit of splitmix64(seed ^ s*K_STAGE ^ i*K_GOLD)
    assign hx   = ((seed_reg ^ sk_reg ^ ik_reg) + K_GOLD);
    assign hy   = y_reg ^ (y_reg >> 27);
    assign keep = z_reg[0] ^ z_reg[31];

    always_ff @(posedge aclk) begin
        x_reg  <= hx;
        p0_reg <= 64'(x_reg[31:0] ^ x_reg[61:30]) * 64'(K_MIX1[31:0]);
        p1_reg <= (x_reg[63:32] ^ {30'd0, x_reg[63:62]}) * K_MIX1[31:0];
        p2_reg <= (x_reg[31:0] ^ x_reg[61:30]) * K_MIX1[63:32];
        y_reg  <= p0_reg + {p1_reg + p2_reg, 32'd0};
        z_reg  <= hy[31:0] * K_MIX2[31:0];
    end

    // scale: magnitude * C / 2^(e/2 + 31), rounded half away, saturated
    assign cmul    = e_reg[0] ? C_ODD : C_EVEN;
    assign sh      = {1'b0, e_reg[6:1]} + 7'd31;
    assign rnd     = 96'(1) << (sh - 7'd1);
    assign shifted = prod_reg >> sh;
    assign lim     = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign rmag    = (shifted > 96'(lim)) ? lim : shifted[31:0];
    assign scaled  = neg_reg ? (64'd0 - {32'd0, rmag}) : {32'd0, rmag};

    always_ff @(posedge aclk) begin
        neg_reg  <= rd_a_reg[63];
        m_reg    <= rd_a_reg[63] ? (64'd0 - rd_a_reg) : rd_a_reg;
        pq_reg   <= 64'(m_reg[31:0]) * 64'(cmul);
        pp_reg   <= 64'(m_reg[63:32]) * 64'(cmul);
        prod_reg <= {pp_reg, 32'd0} + 96'(pq_reg) + rnd;
        diff_reg <= rd_a_reg - rd_b_reg;
    end

    // butterfly pair j, j + len from butterfly count k
    always_comb begin
        bf_mask = len_reg - 1'b1;
        bf_j    = ((k_reg & ~bf_mask) << 1) | (k_reg & bf_mask);
        bf_jb   = bf_j | len_reg;
    end

    // buffer memory, two registered read ports and one write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // sequencer and item handling
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        s_next         = s_reg;
        sk_next        = sk_reg;
        ik_next        = ik_reg;
        l_next         = l_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        lc_next        = lc_reg;
        rc_next        = rc_reg;
        done_next      = done_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        m_valid_next   = out_acc ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        we             = 1'b0;
        waddr          = AW'(idx_reg);
        wdata          = '0;
        addr_a         = AW'(idx_reg);
        addr_b         = AW'(bf_jb);

        // read data arrives in the cycle after the read word
        if (pend_reg) begin
            m_valid_next          = 1'b1;
            m_data_next.value     = rd_a_reg[31:0];
            m_data_next.last      = pend_last_reg;
            m_data_next.ready_res = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                addr_a = AW'(rc_eff);
                if (in_acc && s_data.op == OP_LOAD) begin
                    if (done_reg) begin
                        rc_next = '0;
                    end
                    done_next = 1'b0;
                    if (32'(lc_eff) < MAX_LENGTH) begin
                        we    = 1'b1;
                        waddr = AW'(lc_eff);
                        wdata = {{32{s_data.sample[31]}}, s_data.sample};
                    end
                    lc_next = lc_inc;
                    if (32'(lc_inc) >= 32'(used_eff)) begin
                        state_next = ST_PAD;
                        idx_next   = used_eff;
                        l_next     = l_cur;
                        n_next     = n_cur;
                        r_next     = r_cur;
                        e_next     = 7'(r_cur * l_cur);
                        s_next     = '0;
                        sk_next    = '0;
                    end
                end else if (in_acc) begin
                    if (done_reg) begin
                        pend_next      = 1'b1;
                        pend_last_next = (rc_eff == n_cur - 1'b1);
                        rc_next        = (rc_eff + 1'b1 >= n_cur) ? '0 : rc_eff + 1'b1;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                    end
                end
            end
            ST_PAD: begin
                if (idx_reg < n_reg) begin
                    we       = 1'b1;
                    wdata    = '0;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                idx_next   = '0;
                ik_next    = '0;
                phase_next = '0;
                state_next = (s_reg < r_reg) ? ST_SIGN : ST_SCALE;
            end
            ST_SIGN: begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd4) begin
                    we         = 1'b1;
                    wdata      = keep ? rd_a_reg : (64'd0 - rd_a_reg);
                    phase_next = '0;
                    idx_next   = idx_reg + 1'b1;
                    ik_next    = ik_reg + K_GOLD;
                    if (idx_reg == n_reg - 1'b1) begin
                        if (l_reg == 4'd0) begin
                            s_next     = s_reg + 1'b1;
                            sk_next    = sk_reg + K_STAGE;
                            state_next = ST_ROUND;
                        end else begin
                            k_next     = '0;
                            len_next   = CW'(1);
                            state_next = ST_BFLY;
                        end
                    end
                end
            end
            ST_BFLY: begin
                addr_a     = AW'(bf_j);
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd1) begin
                    we    = 1'b1;
                    waddr = AW'(bf_j);
                    wdata = rd_a_reg + rd_b_reg;
                end else if (phase_reg == 3'd2) begin
                    we         = 1'b1;
                    waddr      = AW'(bf_jb);
                    wdata      = diff_reg;
                    phase_next = '0;
                    k_next     = k_reg + 1'b1;
                    if (k_reg + 1'b1 == (n_reg >> 1)) begin
                        k_next = '0;
                        if ((len_reg << 1) == n_reg) begin
                            s_next     = s_reg + 1'b1;
                            sk_next    = sk_reg + K_STAGE;
                            state_next = ST_ROUND;
                        end else begin
                            len_next = len_reg << 1;
                        end
                    end
                end
            end
            ST_SCALE: begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd4) begin
                    we         = 1'b1;
                    wdata      = scaled;
                    phase_next = '0;
                    idx_next   = idx_reg + 1'b1;
                    if (idx_reg == n_reg - 1'b1) begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            lc_reg        <= '0;
            rc_reg        <= '0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            lc_reg        <= lc_next;
            rc_reg        <= rc_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // datapath and sequencer payload, no reset needed
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        len_reg       <= len_next;
        s_reg         <= s_next;
        sk_reg        <= sk_next;
        ik_reg        <= ik_next;
        l_reg         <= l_next;
        n_reg         <= n_next;
        r_reg         <= r_next;
        e_reg         <= e_next;
        pend_last_reg <= pend_last_next;
        m_data_reg    <= m_data_next;
    end

endmodule

// ===== design/rhr_checker.sv =====
module rhr_assertions
    import rhr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a load word never makes a result
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.op == OP_LOAD && !m_valid |=> !m_valid)
        else $error("result after load word");

    // last only on finished data
    a_last_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.ready_res)
        else $error("last without ready_res");

    // unfinished read returns zero
    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ready_res |-> m_data.value == 32'sd0 && !m_data.last)
        else $error("unfinished read with nonzero value");

endmodule

bind randomized_hadamard_rotation_core rhr_assertions u_rhr_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
